// ===== rtl/dcsd_pkg.sv =====
// Shared types, codes and bias tables for the delta command stream decoder.
// No dependencies; used by every other file under rtl/ except dcsd_fifo.
package dcsd_pkg;

   // Result kind codes as they appear on the result port
   typedef enum logic [1:0] {
      KIND_ADD  = 2'd0,
      KIND_COPY = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   // Parsed command handed from the front end to the back end
   typedef struct packed {
      kind_type    kind;      // KIND_ADD or KIND_COPY
      logic        end_cand;  // copy with an all-zero head byte
      logic        negative;  // offset sign
      logic [30:0] length;    // biased length
      logic [31:0] magnitude; // biased offset magnitude
   } cmd_type;

   // One result beat
   typedef struct packed {
      kind_type    kind;
      logic [31:0] offset;
      logic [30:0] length;
   } rsp_type;

   // Back-end status seen at the top level
   typedef struct packed {
      logic finished;  // end of patch reached, further commands dropped
      logic end_push;  // end marker written into the result queue
   } status_type;

   // Length bias of an add by extra length byte count
   function automatic logic [30:0] add_len_bias(input logic [1:0] nbytes);
      logic [30:0] bias;
      case (nbytes)
         2'd1:    bias = 31'h0000_0040;
         2'd2:    bias = 31'h0000_4040;
         2'd3:    bias = 31'h0040_4040;
         default: bias = 31'h0000_0000;
      endcase
      return bias;
   endfunction

   // Length bias of a copy by length byte count
   function automatic logic [30:0] copy_len_bias(input logic [1:0] nbytes);
      logic [30:0] bias;
      case (nbytes)
         2'd1:    bias = 31'h0000_0010;
         2'd2:    bias = 31'h0000_1010;
         2'd3:    bias = 31'h0010_1010;
         default: bias = 31'h0000_0000;
      endcase
      return bias;
   endfunction

   // Offset magnitude bias by offset byte count minus one
   function automatic logic [31:0] copy_off_bias(input logic [1:0] nbytes);
      logic [31:0] bias;
      case (nbytes)
         2'd1:    bias = 32'h0000_0080;
         2'd2:    bias = 32'h0000_8080;
         2'd3:    bias = 32'h0000_8080;
         default: bias = 32'h0000_0000;
      endcase
      return bias;
   endfunction

endpackage

// ===== rtl/dcsd_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
// No package dependency; WIDTH and DEPTH (a power of two, at least 2) set storage.
module dcsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/dcsd_front.sv =====
// Front end: takes command bytes, tracks fields, emits parsed commands.
// Depends on dcsd_pkg (cmd_type, kind codes, bias functions).
module dcsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [7:0]        cmd_byte,
   input  logic              cmd_full,
   output logic              cmd_push,
   output dcsd_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      PH_HEAD = 2'd0,
      PH_LEN  = 2'd1,
      PH_OFF  = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        expect_copy_ff, expect_copy_in;
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]  len_bytes_ff, len_bytes_in;
   logic [1:0]  off_bytes_ff, off_bytes_in;
   logic [30:0] len_accum_ff, len_accum_in;
   logic [31:0] off_accum_ff, off_accum_in;
   logic        negative_ff, negative_in;
   logic        accept;
   logic [2:0]  bytes_dec;
   logic [30:0] add_len, copy_len;

   assign accept    = push && !cmd_full;
   assign bytes_dec = bytes_left_ff - 3'd1;

   // field sequencing and command build
   always_comb begin
      phase_in       = phase_ff;
      expect_copy_in = expect_copy_ff;
      bytes_left_in  = bytes_left_ff;
      len_bytes_in   = len_bytes_ff;
      off_bytes_in   = off_bytes_ff;
      len_accum_in   = len_accum_ff;
      off_accum_in   = off_accum_ff;
      negative_in    = negative_ff;
      add_len        = '0;
      copy_len       = '0;
      cmd_push       = 1'b0;
      cmd            = '0;
      cmd.kind       = dcsd_pkg::KIND_ADD;
      if (accept) begin
         case (phase_ff)
            PH_LEN: begin
               len_accum_in  = {len_accum_ff[22:0], cmd_byte};
               bytes_left_in = bytes_dec;
               if (bytes_dec == 3'd0) begin
                  if (!expect_copy_ff) begin
                     // add done; zero length is dropped here
                     add_len = len_accum_in + dcsd_pkg::add_len_bias(len_bytes_ff);
                     expect_copy_in = 1'b1;
                     phase_in       = PH_HEAD;
                     cmd_push       = (add_len != '0);
                     cmd.length     = add_len;
                  end else begin
                     phase_in      = PH_OFF;
                     bytes_left_in = {1'b0, off_bytes_ff} + 3'd1;
                  end
               end
            end
            PH_OFF: begin
               if (bytes_left_ff == {1'b0, off_bytes_ff} + 3'd1) begin
                  negative_in  = cmd_byte[7];
                  off_accum_in = {25'd0, cmd_byte[6:0]};
               end else begin
                  off_accum_in = {off_accum_ff[23:0], cmd_byte};
               end
               bytes_left_in = bytes_dec;
               if (bytes_dec == 3'd0) begin
                  // copy done; always forwarded for the position update
                  copy_len       = len_accum_ff + dcsd_pkg::copy_len_bias(len_bytes_ff);
                  phase_in       = PH_HEAD;
                  expect_copy_in = 1'b0;
                  cmd_push       = 1'b1;
                  cmd.kind       = dcsd_pkg::KIND_COPY;
                  cmd.negative   = negative_in;
                  cmd.length     = copy_len;
                  cmd.magnitude  = off_accum_in + dcsd_pkg::copy_off_bias(off_bytes_ff);
                  cmd.end_cand   = (len_bytes_ff == 2'd0) && (off_bytes_ff == 2'd0) &&
                                   (copy_len == '0);
               end
            end
            default: begin
               // head byte
               len_bytes_in = cmd_byte[7:6];
               if (!expect_copy_ff) begin
                  off_bytes_in = 2'd0;
                  len_accum_in = {25'd0, cmd_byte[5:0]};
                  if (cmd_byte[7:6] != 2'd0) begin
                     phase_in      = PH_LEN;
                     bytes_left_in = {1'b0, cmd_byte[7:6]};
                  end else begin
                     expect_copy_in = 1'b1;
                     phase_in       = PH_HEAD;
                     cmd_push       = (cmd_byte[5:0] != 6'd0);
                     cmd.length     = {25'd0, cmd_byte[5:0]};
                  end
               end else begin
                  off_bytes_in = cmd_byte[5:4];
                  len_accum_in = {27'd0, cmd_byte[3:0]};
                  off_accum_in = '0;
                  negative_in  = 1'b0;
                  if (cmd_byte[7:6] != 2'd0) begin
                     phase_in      = PH_LEN;
                     bytes_left_in = {1'b0, cmd_byte[7:6]};
                  end else begin
                     phase_in      = PH_OFF;
                     bytes_left_in = {1'b0, cmd_byte[5:4]} + 3'd1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEAD;
         expect_copy_ff <= 1'b0;
         bytes_left_ff  <= '0;
         len_bytes_ff   <= '0;
         off_bytes_ff   <= '0;
         len_accum_ff   <= '0;
         off_accum_ff   <= '0;
         negative_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         expect_copy_ff <= expect_copy_in;
         bytes_left_ff  <= bytes_left_in;
         len_bytes_ff   <= len_bytes_in;
         off_bytes_ff   <= off_bytes_in;
         len_accum_ff   <= len_accum_in;
         off_accum_ff   <= off_accum_in;
         negative_ff    <= negative_in;
      end
   end

endmodule

// ===== rtl/dcsd_back.sv =====
// Back end: applies parsed commands to the running positions, detects end of patch.
// Depends on dcsd_pkg (cmd_type, rsp_type, status_type, kind codes).
module dcsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [31:0]          csr_wdata,
   input  logic                 cmd_empty,
   input  dcsd_pkg::cmd_type    cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output dcsd_pkg::rsp_type    rsp,
   output dcsd_pkg::status_type status
);

   logic [31:0] add_pos_ff, add_pos_in;
   logic [31:0] copy_pos_ff, copy_pos_in;
   logic        finished_ff, finished_in;
   logic [31:0] abs_off;
   logic        is_end;

   // drain silently after end, else wait for result space
   assign cmd_pop = !cmd_empty && (finished_ff || !rsp_full);

   // absolute offset and exact-zero test for the end marker
   assign abs_off = cmd.negative ? copy_pos_ff - cmd.magnitude : copy_pos_ff + cmd.magnitude;
   assign is_end  = cmd.end_cand &&
                    (cmd.negative ? (cmd.magnitude == copy_pos_ff)
                                  : ((cmd.magnitude == '0) && (copy_pos_ff == '0)));

   always_comb begin
      add_pos_in  = add_pos_ff;
      copy_pos_in = copy_pos_ff;
      finished_in = finished_ff;
      rsp_push    = 1'b0;
      rsp         = '0;
      rsp.kind    = dcsd_pkg::KIND_ADD;
      if (cmd_pop && !finished_ff) begin
         case (cmd.kind)
            dcsd_pkg::KIND_ADD: begin
               rsp_push   = 1'b1;
               rsp.kind   = dcsd_pkg::KIND_ADD;
               rsp.offset = add_pos_ff;
               rsp.length = cmd.length;
               add_pos_in = add_pos_ff + {1'b0, cmd.length};
            end
            dcsd_pkg::KIND_COPY: begin
               if (is_end) begin
                  rsp_push    = 1'b1;
                  rsp.kind    = dcsd_pkg::KIND_END;
                  finished_in = 1'b1;
                  copy_pos_in = '0;
               end else begin
                  copy_pos_in = abs_off;
                  rsp_push    = (cmd.length != '0);
                  rsp.kind    = dcsd_pkg::KIND_COPY;
                  rsp.offset  = abs_off;
                  rsp.length  = cmd.length;
               end
            end
            default: begin
               rsp_push = 1'b0;
            end
         endcase
      end
      // register write reloads the add position
      if (csr_we) begin
         add_pos_in = csr_wdata;
      end
   end

   assign status.finished = finished_ff;
   assign status.end_push = rsp_push && (rsp.kind == dcsd_pkg::KIND_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         add_pos_ff  <= '0;
         copy_pos_ff <= '0;
         finished_ff <= 1'b0;
      end else begin
         add_pos_ff  <= add_pos_in;
         copy_pos_ff <= copy_pos_in;
         finished_ff <= finished_in;
      end
   end

endmodule

// ===== rtl/delta_command_stream_decoder_unit.sv =====
// Delta command stream decoder, top level. One command byte per cycle in while the
// command queue is not full, a rate set by the front end field sequencer. A result
// reaches the rsp ports through both queues: the edge that accepts its last byte
// writes the command queue, and the executor then writes the result queue from it.
// Synchronous active-high reset clears both queues, positions and the end flag.
// Depends on dcsd_pkg, dcsd_fifo, dcsd_front, dcsd_back.
module delta_command_stream_decoder_unit #(
   parameter int CMD_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // command byte beats
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_cmd_byte,
   // result beats
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_out_kind,
   output logic [31:0] rsp_out_offset,
   output logic [30:0] rsp_out_length,
   // add area base register
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int CMD_W = $bits(dcsd_pkg::cmd_type);
   localparam int RSP_W = $bits(dcsd_pkg::rsp_type);

   dcsd_pkg::cmd_type    cmd_wr, cmd_rd;
   dcsd_pkg::rsp_type    rsp_wr, rsp_rd;
   dcsd_pkg::status_type status;
   logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic                 rsp_push, rsp_full;

   assign full = cmd_full;

   // byte parser
   dcsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .cmd_byte (req_cmd_byte),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   // queue between parser and executor
   dcsd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (cmd_rd),
      .empty (cmd_empty)
   );

   // command executor
   dcsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr),
      .status    (status)
   );

   // result output queue
   dcsd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_rd),
      .empty (empty)
   );

   assign rsp_out_kind   = rsp_rd.kind;
   assign rsp_out_offset = rsp_rd.offset;
   assign rsp_out_length = rsp_rd.length;

`ifndef SYNTHESIS
   // parser never writes a full command queue
   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command queue written while full");

   // executor never writes a full result queue
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result queue written while full");

   // end marker sets the end flag
   a_end_sets_finished: assert property (@(posedge clock) disable iff (reset)
      status.end_push |=> status.finished)
      else $error("end marker without end flag");

   // nothing follows the end marker
   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      status.finished |-> !rsp_push)
      else $error("result produced after end of patch");
`endif

endmodule

// ===== sim/dcsd_checker.sv =====
// Scoreboard for the delta command stream decoder: follows every command byte and
// register beat, predicts result beats in order and compares each popped beat.
// Depends on dcsd_pkg for the result kind codes and the result beat layout.
module dcsd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_cmd_byte,
   input  logic        empty,
   input  logic        pop,
   input  logic [1:0]  rsp_out_kind,
   input  logic [31:0] rsp_out_offset,
   input  logic [30:0] rsp_out_length,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          add_count,
   output int          copy_count,
   output int          end_count,
   output logic        head_due,
   output logic        copy_due,
   output logic        patch_done,
   output logic [31:0] copy_pos
);

   // per-byte bias steps of the length and offset fields
   localparam logic [7:0] ADD_LEN_STEP  = 8'h40;
   localparam logic [7:0] COPY_LEN_STEP = 8'h10;
   localparam logic [7:0] OFF_STEP      = 8'h80;

   typedef enum logic [1:0] {
      PH_HEAD = 2'd0,
      PH_LEN  = 2'd1,
      PH_OFF  = 2'd2
   } field_phase_type;

   // parser state
   logic            want_copy;
   field_phase_type phase;
   logic [2:0]      remaining;
   logic [1:0]      nlen;
   logic [1:0]      noff;
   logic [30:0]     len_acc;
   logic [31:0]     off_acc;
   logic            off_neg;
   logic [31:0]     cpos;
   logic [31:0]     apos;
   logic            ended;

   dcsd_pkg::rsp_type expected_cmds[$];
   int      bad   = 0;
   int      depth = 0;
   int      n_add = 0;
   int      n_copy = 0;
   int      n_end = 0;

   assign fail_count = bad;
   assign pending    = depth;
   assign add_count  = n_add;
   assign copy_count = n_copy;
   assign end_count  = n_end;
   assign head_due   = (phase == PH_HEAD) && !ended;
   assign copy_due   = want_copy;
   assign patch_done = ended;
   assign copy_pos   = cpos;

   // bias of an n-byte field: the step repeated in each of the low n bytes
   function automatic logic [31:0] field_bias(input logic [1:0] n, input logic [7:0] step);
      logic [31:0] total;
      total = '0;
      for (int i = 0; i < 3; i++) begin
         if (i < n) total = total + ({24'd0, step} << (8 * i));
      end
      return total;
   endfunction

   task automatic queue_cmd(input dcsd_pkg::kind_type k, input logic [31:0] off,
                            input logic [30:0] len);
      dcsd_pkg::rsp_type r;
      r.kind   = k;
      r.offset = off;
      r.length = len;
      expected_cmds.push_back(r);
   endtask

   task automatic finish_add();
      logic [30:0] len;
      len = 31'(len_acc + field_bias(nlen, ADD_LEN_STEP));
      want_copy = 1'b1;
      phase     = PH_HEAD;
      remaining = '0;
      if (len != '0) begin
         queue_cmd(dcsd_pkg::KIND_ADD, apos, len);
         apos = apos + {1'b0, len};
      end
   endtask

   task automatic finish_copy();
      logic [30:0] len;
      longint      mag;
      longint      landing;
      len  = 31'(len_acc + field_bias(nlen, COPY_LEN_STEP));
      mag  = longint'(off_acc) + longint'(field_bias((noff == 2'd3) ? 2'd2 : noff, OFF_STEP));
      landing = longint'(cpos) + (off_neg ? -mag : mag);
      cpos      = landing[31:0];
      phase     = PH_HEAD;
      remaining = '0;
      // all-zero copy landing exactly on zero closes the patch
      if (nlen == '0 && noff == '0 && len == '0 && landing == 0) begin
         ended = 1'b1;
         queue_cmd(dcsd_pkg::KIND_END, '0, '0);
      end else begin
         want_copy = 1'b0;
         if (len != '0) queue_cmd(dcsd_pkg::KIND_COPY, cpos, len);
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      if (ended) return;
      case (phase)
         PH_LEN: begin
            len_acc   = {len_acc[22:0], b};
            remaining = remaining - 3'd1;
            if (remaining == 3'd0) begin
               if (!want_copy) begin
                  finish_add();
               end else begin
                  phase     = PH_OFF;
                  remaining = {1'b0, noff} + 3'd1;
               end
            end
         end
         PH_OFF: begin
            // first offset byte carries the sign
            if (remaining == {1'b0, noff} + 3'd1) begin
               off_neg = b[7];
               off_acc = {25'd0, b[6:0]};
            end else begin
               off_acc = {off_acc[23:0], b};
            end
            remaining = remaining - 3'd1;
            if (remaining == 3'd0) finish_copy();
         end
         default: begin
            nlen = b[7:6];
            if (!want_copy) begin
               noff    = '0;
               len_acc = {25'd0, b[5:0]};
               if (nlen != '0) begin
                  phase     = PH_LEN;
                  remaining = {1'b0, nlen};
               end else begin
                  finish_add();
               end
            end else begin
               noff    = b[5:4];
               len_acc = {27'd0, b[3:0]};
               off_acc = '0;
               off_neg = 1'b0;
               if (nlen != '0) begin
                  phase     = PH_LEN;
                  remaining = {1'b0, nlen};
               end else begin
                  phase     = PH_OFF;
                  remaining = {1'b0, noff} + 3'd1;
               end
            end
         end
      endcase
   endtask

   // watch both channels and the register port at every edge
   always @(posedge clock) begin : watch
      dcsd_pkg::rsp_type want;
      if (reset) begin
         want_copy = 1'b0;
         phase     = PH_HEAD;
         remaining = '0;
         nlen      = '0;
         noff      = '0;
         len_acc   = '0;
         off_acc   = '0;
         off_neg   = 1'b0;
         cpos      = '0;
         apos      = '0;
         ended     = 1'b0;
         expected_cmds.delete();
      end else begin
         if (csr_we) apos = csr_wdata;
         // result beat
         if (pop && !empty) begin
            if (expected_cmds.size() == 0) begin
               bad++;
               if (bad <= 10)
                  $display("unexpected result beat: kind %0d offset %h length %h",
                           rsp_out_kind, rsp_out_offset, rsp_out_length);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_out_kind !== want.kind || rsp_out_offset !== want.offset ||
                   rsp_out_length !== want.length) begin
                  bad++;
                  if (bad <= 10)
                     $display("mismatch kind/offset/length: exp %0d/%h/%h, got %0d/%h/%h",
                              want.kind, want.offset, want.length,
                              rsp_out_kind, rsp_out_offset, rsp_out_length);
               end
               case (want.kind)
                  dcsd_pkg::KIND_ADD:  n_add++;
                  dcsd_pkg::KIND_COPY: n_copy++;
                  default:             n_end++;
               endcase
            end
         end
         // command byte beat
         if (push && !full) take_byte(req_cmd_byte);
      end
      depth = expected_cmds.size();
   end

endmodule

// ===== sim/tb_delta_command_stream_decoder_unit.sv =====
// Testbench top for the delta command stream decoder: reset, directed and random
// command byte streams under several add-area bases, random stalls, verdict.
// Depends on delta_command_stream_decoder_unit and dcsd_checker.
module tb_delta_command_stream_decoder_unit;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 235;
   localparam int NUM_PHASES   = 5;
   localparam int CALM_BYTES   = 150;

   // head bytes used to walk the copy position back to zero
   localparam logic [7:0] HEAD_ADD_EMPTY  = 8'h00;
   localparam logic [7:0] HEAD_COPY_BARE  = 8'h00;
   localparam logic [7:0] HEAD_COPY_SHORT = 8'h11;
   localparam logic [7:0] HEAD_COPY_LONG  = 8'h31;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_cmd_byte;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_out_kind;
   logic [31:0] rsp_out_offset;
   logic [30:0] rsp_out_length;
   logic        csr_we;
   logic [31:0] csr_wdata;

   int          fail_count;
   int          pending;
   int          add_count;
   int          copy_count;
   int          end_count;
   logic        head_due;
   logic        copy_due;
   logic        patch_done;
   logic [31:0] copy_pos;

   bit          calm = 1'b0;
   int          gap_rate = 0;
   int          bytes_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   delta_command_stream_decoder_unit uut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd_byte   (req_cmd_byte),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_offset (rsp_out_offset),
      .rsp_out_length (rsp_out_length),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   dcsd_checker chk (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd_byte   (req_cmd_byte),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_offset (rsp_out_offset),
      .rsp_out_length (rsp_out_length),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .add_count      (add_count),
      .copy_count     (copy_count),
      .end_count      (end_count),
      .head_due       (head_due),
      .copy_due       (copy_due),
      .patch_done     (patch_done),
      .copy_pos       (copy_pos)
   );

   // one byte beat, held until accepted; optional idle burst after it
   task automatic send_byte(input logic [7:0] b);
      push         <= 1'b1;
      req_cmd_byte <= b;
      do @(posedge clock); while (full !== 1'b0);
      @(negedge clock);
      bytes_sent++;
      if (!calm && $urandom_range(0, 15) < gap_rate) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   // any byte, but never an all-zero copy head (would risk ending the patch)
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (head_due && copy_due && b == 8'h00) b = 8'h01;
      return b;
   endfunction

   // field content leaning toward the extremes
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0:       b = 8'h00;
         1:       b = 8'hFF;
         default: b = 8'($urandom_range(0, 255));
      endcase
      return b;
   endfunction

   // well-formed add or copy, whichever is due
   task automatic send_command();
      logic [1:0] nl;
      logic [1:0] no;
      logic [7:0] head;
      while (!head_due) send_byte(noise_byte());
      nl = 2'($urandom_range(0, 3));
      no = 2'($urandom_range(0, 3));
      if (copy_due) begin
         head = {nl, no, 4'($urandom_range(0, 15))};
         if (head == 8'h00) head = 8'h01;
         send_byte(head);
         repeat (int'(nl)) send_byte(body_byte());
         repeat (int'(no) + 1) send_byte(body_byte());
      end else begin
         head = {nl, 6'($urandom_range(0, 63))};
         send_byte(head);
         repeat (int'(nl)) send_byte(body_byte());
      end
   endtask

   // add-area base write with the pipeline drained
   task automatic write_base(input logic [31:0] value);
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // steer the copy position to zero, close the patch, then trail ignored bytes
   task automatic finish_patch();
      logic [31:0] p;
      logic [31:0] acc;
      while (!patch_done) begin
         if (!head_due) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (!copy_due) begin
            send_byte(HEAD_ADD_EMPTY);
         end else begin
            p = copy_pos;
            if (p <= 32'h7F) begin
               // bare copy back to zero; negative zero when already there
               send_byte(HEAD_COPY_BARE);
               send_byte({1'b1, p[6:0]});
            end else if (p <= 32'h807F) begin
               acc = p - 32'h80;
               send_byte(HEAD_COPY_SHORT);
               send_byte({1'b1, acc[14:8]});
               send_byte(acc[7:0]);
            end else begin
               acc = p - 32'h8080;
               if (acc > 32'h7FFF_FFFF) acc = 32'h7FFF_FFFF;
               send_byte(HEAD_COPY_LONG);
               send_byte({1'b1, acc[30:24]});
               send_byte(acc[23:16]);
               send_byte(acc[15:8]);
               send_byte(acc[7:0]);
            end
         end
      end
      repeat (6) send_byte(8'($urandom_range(0, 255)));
   endtask

   // result side: pop with random stall bursts, none in the final stretch
   initial begin : rsp_side
      int stall;
      int pop_rate;
      stall    = 0;
      pop_rate = 2;
      pop      = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) pop_rate = $urandom_range(0, 4);
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else if (!calm && $urandom_range(0, 15) < pop_rate) begin
            pop   <= 1'b0;
            stall = $urandom_range(1, 13) - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) quiet = 0;
         else quiet++;
      end
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]  directed_bytes [$];
      logic [31:0] base_value;
      int          start;
      int          calm_mark;
      reset        = 1'b1;
      push         = 1'b0;
      req_cmd_byte = 8'h00;
      csr_we       = 1'b0;
      csr_wdata    = 32'h0;
      // zero add, zero-head copy, field extremes, offset wrap, negative zero
      directed_bytes = '{8'h00,
                         8'h00, 8'h05,
                         8'h3F,
                         8'h0F, 8'h7F,
                         8'h40, 8'h00,
                         8'h1F, 8'hFF, 8'hFF,
                         8'hBF, 8'hFF, 8'hFF,
                         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                         8'hFF, 8'hFF, 8'hFF, 8'hFF,
                         8'h01, 8'h80};
      calm_mark = directed_bytes.size() + NUM_PHASES * PHASE_BYTES - CALM_BYTES;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_base(32'h0000_1000);
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      // random phases, one add-area base each
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       base_value = 32'hFFFF_FFFF;
            1:       base_value = 32'h0000_0000;
            2:       base_value = 32'h8000_0000;
            3:       base_value = $urandom;
            default: base_value = 32'hFFFF_FF00;
         endcase
         write_base(base_value);
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            if (bytes_sent >= calm_mark) calm = 1'b1;
            if ($urandom_range(0, 31) == 0) begin
               case ($urandom_range(0, 2))
                  0:       gap_rate = 0;
                  1:       gap_rate = 3;
                  default: gap_rate = 8;
               endcase
            end
            if ($urandom_range(0, 99) < 85) begin
               send_command();
            end else begin
               repeat ($urandom_range(1, 4)) send_byte(noise_byte());
            end
         end
      end

      calm = 1'b1;
      finish_patch();
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Streamed %0d command bytes under %0d add-area bases, with stalls on both sides.",
               bytes_sent, NUM_PHASES + 1);
      $display("Compared %0d add, %0d copy and %0d end-of-patch beats.",
               add_count, copy_count, end_count);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dcsd_pkg.sv
rtl/dcsd_fifo.sv
rtl/dcsd_front.sv
rtl/dcsd_back.sv
rtl/delta_command_stream_decoder_unit.sv
sim/dcsd_checker.sv
sim/tb_delta_command_stream_decoder_unit.sv
